// File: hdl/spfe_pkg.sv
package spfe_pkg;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_SAMPLE_FORMAT = 2'd0;
	localparam logic [1:0] REG_CHANNEL_COUNT = 2'd1;
	localparam logic [1:0] REG_GAIN          = 2'd2;

	// Sample format codes
	localparam logic [2:0] FMT_U8  = 3'd0;
	localparam logic [2:0] FMT_S16 = 3'd1;
	localparam logic [2:0] FMT_S24 = 3'd2;
	localparam logic [2:0] FMT_S32 = 3'd3;
	localparam logic [2:0] FMT_F32 = 3'd4;
	localparam logic [2:0] FMT_F64 = 3'd5;

	// Reset values
	localparam logic [2:0]  RST_SAMPLE_FORMAT = FMT_S16;
	localparam logic [3:0]  RST_CHANNEL_COUNT = 4'd2;
	localparam logic [23:0] RST_GAIN          = 24'd65536;

	// Integer full-scale factors (2^(n-1) - 1)
	localparam logic [31:0] K_U8  = 32'd127;
	localparam logic [31:0] K_S16 = 32'd32767;
	localparam logic [31:0] K_S24 = 32'd8388607;
	localparam logic [31:0] K_S32 = 32'd2147483647;

	// Word limit per frame
	localparam int WORD_LIMIT = 8;

	typedef struct packed {
		logic signed [35:0] left_sample;
		logic signed [35:0] right_sample;
		logic               end_of_buffer;
	} frame_t;

	typedef struct packed {
		logic [63:0] sample_word;
		logic [3:0]  byte_count;
		logic [2:0]  channel_index;
		logic        last_of_frame;
		logic        end_of_buffer_out;
	} result_t;

	typedef struct packed {
		logic [2:0]  sample_format;
		logic [3:0]  channel_count;
		logic [23:0] gain_q8_16;
	} cfg_t;

	// One channel word on its way into the encoder
	typedef struct packed {
		logic               valid;
		logic signed [61:0] x;
		logic [2:0]         ch;
		logic               last;
		logic               eob;
	} chan_item_t;

	// Position of the leading one of a 49-bit magnitude (0 for zero)
	function automatic logic [5:0] top_bit(input logic [48:0] m);
		logic [5:0] p;
		p = 6'd0;
		for (int i = 1; i < 49; i++) begin
			if (m[i]) begin
				p = 6'(i);
			end
		end
		return p;
	endfunction

endpackage

// File: hdl/spfe_gain.sv
module spfe_gain (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  spfe_pkg::frame_t    frame,
	input  logic [23:0]         gain_q8_16,
	input  logic                take,
	output logic                busy,
	output logic                valid,
	output logic signed [60:0]  pl,
	output logic signed [60:0]  pr,
	output logic                eob
);

	logic               v_s1, v_s2;
	logic [41:0]        ll_s1, rl_s1;
	logic signed [42:0] lh_s1, rh_s1;
	logic               eob_s1;
	logic signed [60:0] pl_s2, pr_s2;
	logic               eob_s2;
	logic               adv1, adv2;
	logic signed [24:0] g;
	logic signed [17:0] lh_in, rh_in;

	assign g     = $signed({1'b0, gain_q8_16});
	assign lh_in = frame.left_sample[35:18];
	assign rh_in = frame.right_sample[35:18];

	// Pipeline advance: a stage moves when the next one can take it
	assign adv2 = !v_s2 || take;
	assign adv1 = !v_s1 || adv2;
	assign busy = !adv1;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= start;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// Stage 1: split partial products of sample times gain
	always_ff @(posedge clk) begin
		if (adv1 && start) begin
			ll_s1  <= 42'(frame.left_sample[17:0] * gain_q8_16);
			rl_s1  <= 42'(frame.right_sample[17:0] * gain_q8_16);
			lh_s1  <= 43'(lh_in * g);
			rh_s1  <= 43'(rh_in * g);
			eob_s1 <= frame.end_of_buffer;
		end
	end

	// Stage 2: combine partial products
	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			pl_s2  <= $signed({lh_s1, 18'd0}) + $signed({19'd0, ll_s1});
			pr_s2  <= $signed({rh_s1, 18'd0}) + $signed({19'd0, rl_s1});
			eob_s2 <= eob_s1;
		end
	end

	assign valid = v_s2;
	assign pl    = pl_s2;
	assign pr    = pr_s2;
	assign eob   = eob_s2;

endmodule

// File: hdl/spfe_expand.sv
module spfe_expand #(
	parameter int MAX_CHANNELS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   valid,
	input  logic signed [60:0]     pl,
	input  logic signed [60:0]     pr,
	input  logic                   eob,
	input  logic [3:0]             channel_count,
	output logic                   take,
	output spfe_pkg::chan_item_t   item
);

	localparam int LIM = (MAX_CHANNELS < spfe_pkg::WORD_LIMIT) ?
		MAX_CHANNELS : spfe_pkg::WORD_LIMIT;

	logic               v_q;
	logic signed [61:0] xl_q, xr_q;
	logic               eob_q;
	logic [2:0]         ch_q, lastch_q;
	logic               last_now;
	logic               mono;
	logic [2:0]         lastch_new;

	assign mono = channel_count <= 4'd1;

	// Index of the final word for the current channel count
	always_comb begin
		if (mono) begin
			lastch_new = 3'd0;
		end else if (int'(channel_count) > LIM) begin
			lastch_new = 3'(LIM - 1);
		end else begin
			lastch_new = 3'(channel_count - 4'd1);
		end
	end

	assign last_now = v_q && (ch_q == lastch_q);
	assign take     = !v_q || last_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q  <= 1'b0;
			ch_q <= 3'd0;
		end else if (take) begin
			v_q  <= valid;
			ch_q <= 3'd0;
		end else begin
			ch_q <= ch_q + 3'd1;
		end
	end

	// Frame hold: stereo doubles each side, mono sums both
	always_ff @(posedge clk) begin
		if (take && valid) begin
			xl_q     <= mono ? (62'(pl) + 62'(pr)) : (62'(pl) <<< 1);
			xr_q     <= 62'(pr) <<< 1;
			eob_q    <= eob;
			lastch_q <= lastch_new;
		end
	end

	// Channel word: extra channels carry zero
	always_comb begin
		item.valid = v_q;
		item.ch    = ch_q;
		item.last  = last_now;
		item.eob   = last_now && eob_q;
		case (ch_q)
			3'd0:    item.x = xl_q;
			3'd1:    item.x = xr_q;
			default: item.x = '0;
		endcase
	end

endmodule

// File: hdl/spfe_encode.sv
module spfe_encode (
	input  logic                  clk,
	input  logic                  arst_n,
	input  spfe_pkg::chan_item_t  item,
	input  logic [2:0]            sample_format,
	output logic                  result_valid,
	output spfe_pkg::result_t     result
);

	localparam logic signed [61:0] ONE  = 62'sd1 <<< 48;
	localparam logic signed [61:0] MONE = -(62'sd1 <<< 48);

	// Stage 3 registers: clamp and magnitude
	logic        v_s3, neg_s3, last_s3, eob_s3;
	logic [2:0]  ch_s3;
	logic [48:0] m_s3;
	// Stage 4: products and leading-one position
	logic        v_s4, neg_s4, last_s4, eob_s4;
	logic [2:0]  ch_s4;
	logic [48:0] m_s4;
	logic [55:0] plo_s4;
	logic [56:0] phi_s4;
	logic [5:0]  p_s4;
	// Stage 5: rounded integer and normalized magnitude
	logic        v_s5, neg_s5, last_s5, eob_s5, zero_s5;
	logic [2:0]  ch_s5;
	logic [31:0] r_s5;
	logic [48:0] norm_s5;
	logic [5:0]  p_s5;
	// Stage 6: output register
	logic                v_s6;
	spfe_pkg::result_t   res_s6;

	logic [48:0] m_c;
	logic        neg_c;
	logic [31:0] k_c;
	logic [56:0] a_c, t_c;
	logic [23:0] mant_c;
	logic [24:0] rem_c, ms_c;
	logic        up_c;
	logic [7:0]  exs_c;
	logic [22:0] fr_c;
	logic [31:0] rs_c;
	logic [63:0] word_c;
	logic [3:0]  bytes_c;

	// Clamp to plus or minus one
	always_comb begin
		if (item.x > ONE) begin
			neg_c = 1'b0;
			m_c   = 49'h1_0000_0000_0000;
		end else if (item.x < MONE) begin
			neg_c = 1'b1;
			m_c   = 49'h1_0000_0000_0000;
		end else begin
			neg_c = item.x < 0;
			m_c   = neg_c ? 49'(-item.x) : 49'(item.x);
		end
	end

	// Scale factor by format
	always_comb begin
		case (sample_format)
			spfe_pkg::FMT_U8:  k_c = spfe_pkg::K_U8;
			spfe_pkg::FMT_S24: k_c = spfe_pkg::K_S24;
			spfe_pkg::FMT_S32: k_c = spfe_pkg::K_S32;
			default:           k_c = spfe_pkg::K_S16;
		endcase
	end

	assign a_c = 57'(plo_s4) + (57'd1 << 47);
	assign t_c = (a_c >> 24) + phi_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s3 <= item.valid;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		neg_s3  <= neg_c;
		m_s3    <= m_c;
		ch_s3   <= item.ch;
		last_s3 <= item.last;
		eob_s3  <= item.eob;

		plo_s4  <= 56'(m_s3[23:0] * k_c);
		phi_s4  <= 57'(m_s3[48:24] * k_c);
		p_s4    <= spfe_pkg::top_bit(m_s3);
		m_s4    <= m_s3;
		neg_s4  <= neg_s3;
		ch_s4   <= ch_s3;
		last_s4 <= last_s3;
		eob_s4  <= eob_s3;

		r_s5    <= t_c[55:24];
		norm_s5 <= m_s4 << (6'd48 - p_s4);
		p_s5    <= p_s4;
		zero_s5 <= m_s4 == '0;
		neg_s5  <= neg_s4;
		ch_s5   <= ch_s4;
		last_s5 <= last_s4;
		eob_s5  <= eob_s4;

		res_s6.sample_word       <= word_c;
		res_s6.byte_count        <= bytes_c;
		res_s6.channel_index     <= ch_s5;
		res_s6.last_of_frame     <= last_s5;
		res_s6.end_of_buffer_out <= eob_s5;
	end

	// Single precision rounding, nearest even
	always_comb begin
		mant_c = norm_s5[48:25];
		rem_c  = norm_s5[24:0];
		up_c   = (rem_c > 25'h100_0000) || ((rem_c == 25'h100_0000) && mant_c[0]);
		ms_c   = {1'b0, mant_c} + 25'(up_c);
		if (ms_c[24]) begin
			exs_c = 8'(p_s5) + 8'd80;
			fr_c  = ms_c[23:1];
		end else begin
			exs_c = 8'(p_s5) + 8'd79;
			fr_c  = ms_c[22:0];
		end
	end

	// Final word assembly
	always_comb begin
		rs_c = neg_s5 ? (32'd0 - r_s5) : r_s5;
		case (sample_format)
			spfe_pkg::FMT_U8: begin
				bytes_c = 4'd1;
				word_c  = {56'd0, neg_s5 ? (8'd128 - r_s5[7:0]) : (8'd128 + r_s5[7:0])};
			end
			spfe_pkg::FMT_S24: begin
				bytes_c = 4'd3;
				word_c  = {40'd0, rs_c[23:0]};
			end
			spfe_pkg::FMT_S32: begin
				bytes_c = 4'd4;
				word_c  = {32'd0, rs_c};
			end
			spfe_pkg::FMT_F32: begin
				bytes_c = 4'd4;
				word_c  = zero_s5 ? 64'd0 : {32'd0, neg_s5, exs_c, fr_c};
			end
			spfe_pkg::FMT_F64: begin
				bytes_c = 4'd8;
				word_c  = zero_s5 ? 64'd0 :
					{neg_s5, 11'(p_s5) + 11'd975, norm_s5[47:0], 4'd0};
			end
			default: begin
				bytes_c = 4'd2;
				word_c  = {48'd0, rs_c[15:0]};
			end
		endcase
	end

	assign result_valid = v_s6;
	assign result       = res_s6;

endmodule

// File: hdl/stereo_to_pcm_frame_encode_unit.sv
// Stereo frame to PCM sample encoder.
// Input: a frame (left, right Q4.31, end_of_buffer) is taken at a clock edge
// with start high and busy low. A frame yields channel_count words, capped
// by MAX_CHANNELS, WORD_LIMIT (one in mono), one per cycle, in channel order.
// Output: result_valid marks each word for exactly one cycle; the receiver
// must take it then, as there is no backpressure on results.
// Configuration: cfg_valid/cfg_ready write channel, cfg_ready always high;
// index 0 sample_format, 1 channel_count, 2 gain. Write only while idle.
// Path: gain stages 1 and 2, the channel expander register, then encoder
// stages 3, 4, 5 and 6, the last being the output register. Throughput:
// one word per cycle, the words of a frame back to back. The channel
// expander, which emits one word a cycle, sets this rate; busy rises when
// the two gain stages before it are full and it does not take a frame.
// Reset: asynchronous, active low; clears all valid bits and loads the
// register defaults (s16, two channels, unity gain).
module stereo_to_pcm_frame_encode_unit #(
	parameter int MAX_CHANNELS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  spfe_pkg::frame_t   frame,
	output logic               result_valid,
	output spfe_pkg::result_t  result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [23:0]        cfg_data
);

	spfe_pkg::cfg_t       cfg_q;
	spfe_pkg::chan_item_t item;
	logic                 take, g_valid, g_eob;
	logic signed [60:0]   pl, pr;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_format <= spfe_pkg::RST_SAMPLE_FORMAT;
			cfg_q.channel_count <= spfe_pkg::RST_CHANNEL_COUNT;
			cfg_q.gain_q8_16    <= spfe_pkg::RST_GAIN;
		end else if (cfg_valid) begin
			case (cfg_index)
				spfe_pkg::REG_SAMPLE_FORMAT: cfg_q.sample_format <= cfg_data[2:0];
				spfe_pkg::REG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_data[3:0];
				spfe_pkg::REG_GAIN:          cfg_q.gain_q8_16    <= cfg_data;
				default: ;
			endcase
		end
	end

	spfe_gain u_gain (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.frame      (frame),
		.gain_q8_16 (cfg_q.gain_q8_16),
		.take       (take),
		.busy       (busy),
		.valid      (g_valid),
		.pl         (pl),
		.pr         (pr),
		.eob        (g_eob)
	);

	spfe_expand #(
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_expand (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid         (g_valid),
		.pl            (pl),
		.pr            (pr),
		.eob           (g_eob),
		.channel_count (cfg_q.channel_count),
		.take          (take),
		.item          (item)
	);

	spfe_encode u_encode (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (item),
		.sample_format (cfg_q.sample_format),
		.result_valid  (result_valid),
		.result        (result)
	);

endmodule

// File: hdl/spfe_checker.sv
module spfe_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               result_valid,
	input spfe_pkg::result_t  result
);

	// Words of one frame come out back to back in channel order
	a_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last_of_frame |=> result_valid &&
		result.channel_index == $past(result.channel_index) + 3'd1)
		else $error("frame words not contiguous");

	// A word past the first always follows another word
	a_follows: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.channel_index != 3'd0 |-> $past(result_valid))
		else $error("channel word without predecessor");

	// End of buffer is only flagged on the frame's last word
	a_eob_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last_of_frame |-> !result.end_of_buffer_out)
		else $error("end of buffer on inner word");

	// Bytes beyond byte_count are zero for one-byte words
	a_u8_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.byte_count == 4'd1 |->
		result.sample_word[63:8] == 56'd0)
		else $error("stray high bytes");

endmodule

bind stereo_to_pcm_frame_encode_unit spfe_checker u_spfe_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result       (result)
);

// File: tb/stereo_to_pcm_frame_encode_unit_tb.sv
`timescale 1ns / 1ps

module stereo_to_pcm_frame_encode_unit_tb;

	localparam int MAX_CH = 8;
	localparam int SETTLE_CYCLES = 14;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	spfe_pkg::frame_t  frame;
	logic       result_valid;
	spfe_pkg::result_t result;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_index;
	logic [23:0] cfg_data;

	// Shadow copy of the block registers
	logic [2:0]  fmt_r;
	logic [3:0]  chans_r;
	logic [23:0] gain_r;

	spfe_pkg::result_t pcm_words_q[$];
	int      err_count;
	int      mismatch_count;

	stereo_to_pcm_frame_encode_unit #(.MAX_CHANNELS(MAX_CH)) DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .frame(frame),
		.result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// round(m * k / 2^48), half up on magnitude
	function automatic logic [63:0] pcm_scale(logic [63:0] m, logic [63:0] k);
		logic [63:0] hi, lo, a, t;
		hi = m >> 24;
		lo = m & 64'hFFFFFF;
		a = lo * k + (64'd1 << 47);
		t = (a >> 24) + hi * k;
		return t >> 24;
	endfunction

	function automatic int lead_one(logic [63:0] m);
		int p;
		p = 0;
		for (int i = 1; i < 64; i++) begin
			if (m[i]) begin
				p = i;
			end
		end
		return p;
	endfunction

	// Magnitude with 48 fraction bits to IEEE single, nearest even
	function automatic logic [63:0] pcm_single(logic neg, logic [63:0] m);
		int p, sh;
		logic [63:0] mant, ex, rem, half;
		if (m == 0) begin
			return 64'd0;
		end
		p = lead_one(m);
		ex = 64'(p - 48 + 127);
		if (p <= 23) begin
			mant = m << (23 - p);
		end else begin
			sh = p - 23;
			mant = m >> sh;
			rem = m & ((64'd1 << sh) - 64'd1);
			half = 64'd1 << (sh - 1);
			if (rem > half || (rem == half && mant[0])) begin
				mant = mant + 64'd1;
			end
			if (mant >> 24) begin
				mant = mant >> 1;
				ex = ex + 64'd1;
			end
		end
		return (64'(neg) << 31) | (ex << 23) | (mant & 64'h7FFFFF);
	endfunction

	function automatic logic [63:0] pcm_double(logic neg, logic [63:0] m);
		int p;
		logic [63:0] ex, mant;
		if (m == 0) begin
			return 64'd0;
		end
		p = lead_one(m);
		ex = 64'(p - 48 + 1023);
		mant = m << (52 - p);
		return (64'(neg) << 63) | (ex << 52) | (mant & 64'hFFFFFFFFFFFFF);
	endfunction

	// Clamp one channel value and encode it in the current format
	function automatic spfe_pkg::result_t pcm_encode(longint x, int ch, logic last,
		logic eob);
		spfe_pkg::result_t r;
		longint one;
		logic neg;
		logic [63:0] m, v;
		one = longint'(1) << 48;
		if (x > one) x = one;
		if (x < -one) x = -one;
		neg = x < 0;
		m = neg ? 64'(-x) : 64'(x);
		case (fmt_r)
			spfe_pkg::FMT_U8: begin
				v = pcm_scale(m, 64'(spfe_pkg::K_U8));
				r.sample_word = neg ? 64'd128 - v : 64'd128 + v;
				r.byte_count = 4'd1;
			end
			spfe_pkg::FMT_S24: begin
				v = pcm_scale(m, 64'(spfe_pkg::K_S24));
				r.sample_word = (neg ? -v : v) & 64'hFFFFFF;
				r.byte_count = 4'd3;
			end
			spfe_pkg::FMT_S32: begin
				v = pcm_scale(m, 64'(spfe_pkg::K_S32));
				r.sample_word = (neg ? -v : v) & 64'hFFFFFFFF;
				r.byte_count = 4'd4;
			end
			spfe_pkg::FMT_F32: begin
				r.sample_word = pcm_single(neg, m);
				r.byte_count = 4'd4;
			end
			spfe_pkg::FMT_F64: begin
				r.sample_word = pcm_double(neg, m);
				r.byte_count = 4'd8;
			end
			default: begin
				v = pcm_scale(m, 64'(spfe_pkg::K_S16));
				r.sample_word = (neg ? -v : v) & 64'hFFFF;
				r.byte_count = 4'd2;
			end
		endcase
		r.channel_index = 3'(ch);
		r.last_of_frame = last;
		r.end_of_buffer_out = last & eob;
		return r;
	endfunction

	// Queue the words one accepted frame should produce
	task automatic predict_frame(spfe_pkg::frame_t f);
		longint pl, pr, x;
		int n;
		pl = f.left_sample;
		pr = f.right_sample;
		pl = pl * longint'(gain_r);
		pr = pr * longint'(gain_r);
		n = chans_r;
		if (n <= 1) begin
			pcm_words_q.push_back(pcm_encode(pl + pr, 0, 1'b1, f.end_of_buffer));
		end else begin
			if (n > MAX_CH) n = MAX_CH;
			if (n > spfe_pkg::WORD_LIMIT) n = spfe_pkg::WORD_LIMIT;
			for (int c = 0; c < n; c++) begin
				x = (c == 0) ? pl * 2 : (c == 1) ? pr * 2 : 0;
				pcm_words_q.push_back(pcm_encode(x, c, c == n - 1, f.end_of_buffer));
			end
		end
	endtask

	// Offer one frame and hold it until accepted; start stays high afterwards
	task automatic send_frame(logic signed [35:0] l, logic signed [35:0] r, logic eob);
		spfe_pkg::frame_t f;
		f.left_sample = l;
		f.right_sample = r;
		f.end_of_buffer = eob;
		start <= 1'b1;
		frame <= f;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		predict_frame(f);
	endtask

	task automatic idle_cycles(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Wait until every word has come out and the pipeline is empty
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pcm_words_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Valid stays high across consecutive writes; the caller drops it
	task automatic write_reg(logic [1:0] idx, logic [23:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		forever begin
			@(posedge clk);
			if (cfg_ready) break;
		end
		case (idx)
			spfe_pkg::REG_SAMPLE_FORMAT: fmt_r = data[2:0];
			spfe_pkg::REG_CHANNEL_COUNT: chans_r = data[3:0];
			spfe_pkg::REG_GAIN:          gain_r = data;
			default: ;
		endcase
	endtask

	task automatic set_config(logic [2:0] f, logic [3:0] n, logic [23:0] g);
		drain();
		write_reg(spfe_pkg::REG_SAMPLE_FORMAT, 24'(f));
		write_reg(spfe_pkg::REG_CHANNEL_COUNT, 24'(n));
		write_reg(spfe_pkg::REG_GAIN, g);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [35:0] rand_sample();
		logic [35:0] v;
		v = 36'({$urandom(), $urandom()});
		case ($urandom_range(0, 5))
			0, 1: return 36'(signed'(v[31:0]));
			2: return v;
			3: return $urandom_range(0, 1) ? 36'sd2147483648 + $urandom_range(0, 3) - 2
			                               : -36'sd2147483648 + $urandom_range(0, 3) - 2;
			4: return 36'(signed'(v[15:0]));
			default: return 36'(signed'(v[27:0]));
		endcase
	endfunction

	function automatic logic [23:0] rand_gain();
		case ($urandom_range(0, 4))
			0: return 24'd65536;
			1: return 24'(32'($urandom_range(0, 131072)));
			2: return 24'(32'($urandom_range(0, 1))) * 24'hFFFFFF;
			default: return 24'($urandom());
		endcase
	endfunction

	// Register defaults after reset, with field extremes
	task automatic test_reset_defaults();
		send_frame(36'sd0, 36'sd0, 1'b0);
		send_frame(36'sh7FFFFFFFF, 36'sh800000000, 1'b1);
		send_frame(36'sd2147483648, -36'sd2147483648, 1'b0);
		send_frame(36'sd1073741824, -36'sd1073741824, 1'b1);
		send_frame(36'sd1, -36'sd1, 1'b0);
	endtask

	// Every format code, unknown ones included, over channel count extremes
	task automatic test_formats();
		logic [3:0] counts[8] = '{4'd1, 4'd2, 4'd0, 4'd8, 4'd15, 4'd3, 4'd1, 4'd2};
		for (int f = 0; f < 8; f++) begin
			set_config(3'(f), counts[f], (f == 2) ? 24'hFFFFFF : (f == 3) ? 24'd0 : 24'd65536);
			send_frame(36'sd2147483648, -36'sd1073741824, 1'b1);
			send_frame(-36'sd12345678, 36'sd98765, 1'b0);
		end
	endtask

	// Random phases with random settings; the last one runs without gaps
	task automatic test_random_stream();
		int phase_len;
		int sent;
		sent = 0;
		while (sent < 85) begin
			set_config(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)), rand_gain());
			phase_len = $urandom_range(6, 14);
			for (int i = 0; i < phase_len; i++) begin
				if (sent < 65 && $urandom_range(0, 3) == 0) begin
					idle_cycles($urandom_range(1, 9));
				end
				send_frame(rand_sample(), rand_sample(), 1'($urandom_range(0, 1)));
				sent++;
			end
		end
	endtask

	// Compare each word with the oldest expectation
	always @(posedge clk) begin
		spfe_pkg::result_t want;
		if (arst_n && result_valid) begin
			if (pcm_words_q.size() == 0) begin
				err_count++;
				if (mismatch_count < 10) begin
					$display("unexpected word %h", result);
				end
				mismatch_count++;
			end else begin
				want = pcm_words_q.pop_front();
				if (result !== want) begin
					err_count++;
					if (mismatch_count < 10) begin
						$display("mismatch: word exp %h got %h, bytes exp %0d got %0d",
							want.sample_word, result.sample_word,
							want.byte_count, result.byte_count);
						$display("  ch exp %0d got %0d, last exp %b got %b, eob exp %b got %b",
							want.channel_index, result.channel_index,
							want.last_of_frame, result.last_of_frame,
							want.end_of_buffer_out, result.end_of_buffer_out);
					end
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		#5ms;
		$display("stereo_to_pcm_frame_encode_unit_tb: done, errors");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		frame = '0;
		cfg_valid = 1'b0;
		cfg_index = spfe_pkg::REG_SAMPLE_FORMAT;
		cfg_data = '0;
		err_count = 0;
		mismatch_count = 0;
		fmt_r = spfe_pkg::RST_SAMPLE_FORMAT;
		chans_r = spfe_pkg::RST_CHANNEL_COUNT;
		gain_r = spfe_pkg::RST_GAIN;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_formats();
		test_random_stream();
		drain();
		if (pcm_words_q.size() != 0) begin
			err_count++;
		end

		if (err_count == 0) begin
			$display("stereo_to_pcm_frame_encode_unit_tb: done, clean");
		end else begin
			$display("stereo_to_pcm_frame_encode_unit_tb: done, errors");
		end
		$finish;
	end

endmodule
